### hdl/lcg48_pkg.sv
package lcg48_pkg;

	localparam int STATE_W = 48;
	localparam int MUL_W   = 35;
	localparam int DRAW_W  = 31;

	localparam logic [MUL_W-1:0]   LCG_MUL = 35'h5DEECE66D;
	localparam logic [STATE_W-1:0] LCG_ADD = 48'hB;

	typedef enum logic [2:0] {
		OP_SEED   = 3'd0,
		OP_NEXT   = 3'd1,
		OP_BOUND  = 3'd2,
		OP_LONG   = 3'd3,
		OP_DOUBLE = 3'd4
	} op_t;

	// Handshake status reported by the serial arithmetic units.
	typedef struct packed {
		logic busy;
		logic done;
	} unit_status_t;

endpackage

### hdl/lcg48_random_generator_unit.sv
// 48-bit linear congruential generator with the recurrence
// state <- (state * 0x5DEECE66D + 0xB) mod 2^48, one transaction in and one
// result transaction out per operation: seed, next bits, bounded int, long and
// double bits. The state is zero after reset. Every draw updates the state
// through a bit-serial multiplier that consumes one bit of the 35-bit
// multiplier constant per cycle. Seed and undefined operations need no draw,
// next bits take one draw, long and double bits take two. A bounded int with a
// power-of-two bound takes one draw, then shifts the draw right (up to 31 shifts).
// Other bounds follow each draw attempt with a bit-serial remainder unit that
// retires one dividend bit per cycle; rejected draws repeat draw and remainder. A
// non-positive bound returns zero without a draw. The block works on one
// transaction at a time; a finished result sits in the output register while
// the next input transaction is accepted.
module lcg48_random_generator_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         op,
	input  logic signed [63:0] seed_value,
	input  logic [5:0]         bit_count,
	input  logic signed [31:0] bound,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [63:0] value
);
	import lcg48_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_START,
		S_WAIT,
		S_POST,
		S_PSHIFT,
		S_DIVWAIT,
		S_CHECK,
		S_OUT
	} fsm_t;

	fsm_t               state_q;
	logic [STATE_W-1:0] lcg_state_q;
	logic [2:0]         op_q;
	logic [5:0]         nb_q;
	logic [31:0]        bound_q;
	logic               phase_q;
	logic [31:0]        hi_q;
	logic [DRAW_W-1:0]  draw_q;
	logic [31:0]        shift_q;
	logic [63:0]        res_q;
	logic               out_valid_q;
	logic [63:0]        value_q;

	logic               in_fire;
	logic [5:0]         nb_clamped;
	logic [STATE_W-1:0] step_next;
	unit_status_t       step_st;
	unit_status_t       div_st;
	logic [DRAW_W-1:0]  div_rem;
	logic               div_start;
	logic [31:0]        top32;
	logic [DRAW_W-1:0]  top31;
	logic [5:0]         sh_amt;
	logic [31:0]        top_shifted;
	logic               bound_pow2;
	logic [31:0]        reject_chk;

	assign in_ready = (state_q == S_IDLE);
	assign in_fire  = in_valid && in_ready;

	// Out-of-range bit counts saturate into 1..32.
	always_comb begin
		if (bit_count == 6'd0) begin
			nb_clamped = 6'd1;
		end else if (bit_count > 6'd32) begin
			nb_clamped = 6'd32;
		end else begin
			nb_clamped = bit_count;
		end
	end

	assign top32       = lcg_state_q[STATE_W-1 -: 32];
	assign top31       = lcg_state_q[STATE_W-1 -: DRAW_W];
	assign sh_amt      = 6'd32 - nb_q;
	assign top_shifted = top32 >> sh_amt[4:0];
	assign bound_pow2  = ((bound_q & (bound_q - 32'd1)) == 32'd0);
	// A draw is rejected when draw - rem + (bound - 1) overflows 32-bit signed.
	assign reject_chk  = {1'b0, draw_q} - {1'b0, div_rem} + (bound_q - 32'd1);
	assign div_start   = (state_q == S_POST) && (op_q == OP_BOUND) && !bound_pow2;

	lcg48_step u_step (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (state_q == S_START),
		.cur_state  (lcg_state_q),
		.next_state (step_next),
		.status     (step_st)
	);

	lcg48_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (top31),
		.divisor   (bound_q[DRAW_W-1:0]),
		.remainder (div_rem),
		.status    (div_st)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			lcg_state_q <= '0;
			phase_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// In S_OUT a draining result is replaced by the new one below.
			if (out_valid_q && out_ready && (state_q != S_OUT)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						phase_q <= 1'b0;
						case (op)
							OP_SEED: begin
								lcg_state_q <= seed_value[STATE_W-1:0] ^ STATE_W'(LCG_MUL);
								state_q     <= S_OUT;
							end
							OP_NEXT, OP_LONG, OP_DOUBLE: begin
								state_q <= S_START;
							end
							OP_BOUND: begin
								// Zero or negative bounds give zero without a draw.
								if (bound[31] || bound == 32'sd0) begin
									state_q <= S_OUT;
								end else begin
									state_q <= S_START;
								end
							end
							default: begin
								state_q <= S_OUT;
							end
						endcase
					end
				end
				S_START: begin
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (step_st.done) begin
						lcg_state_q <= step_next;
						state_q     <= S_POST;
					end
				end
				S_POST: begin
					case (op_q)
						OP_BOUND: begin
							state_q <= bound_pow2 ? S_PSHIFT : S_DIVWAIT;
						end
						OP_LONG, OP_DOUBLE: begin
							if (!phase_q) begin
								phase_q <= 1'b1;
								state_q <= S_START;
							end else begin
								state_q <= S_OUT;
							end
						end
						default: begin
							state_q <= S_OUT;
						end
					endcase
				end
				S_PSHIFT: begin
					if (shift_q[31]) begin
						state_q <= S_OUT;
					end
				end
				S_DIVWAIT: begin
					if (div_st.done) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					state_q <= reject_chk[31] ? S_START : S_OUT;
				end
				S_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers; these need no reset.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					op_q    <= op;
					nb_q    <= nb_clamped;
					bound_q <= bound;
					res_q   <= '0;
				end
			end
			S_POST: begin
				case (op_q)
					OP_NEXT: begin
						if (nb_q == 6'd32) begin
							res_q <= {{32{top32[31]}}, top32};
						end else begin
							res_q <= {32'd0, top_shifted};
						end
					end
					OP_BOUND: begin
						// (bound * draw) >> 31 for bound = 2^k is draw >> (31 - k).
						draw_q  <= top31;
						shift_q <= bound_q;
					end
					OP_LONG: begin
						if (!phase_q) begin
							hi_q <= top32;
						end else begin
							res_q <= {hi_q - {31'd0, top32[31]}, top32};
						end
					end
					OP_DOUBLE: begin
						if (!phase_q) begin
							hi_q <= {6'd0, lcg_state_q[STATE_W-1 -: 26]};
						end else begin
							res_q <= {11'd0, hi_q[25:0], lcg_state_q[STATE_W-1 -: 27]};
						end
					end
					default: begin
						res_q <= '0;
					end
				endcase
			end
			S_PSHIFT: begin
				if (shift_q[31]) begin
					res_q <= {33'd0, draw_q};
				end else begin
					shift_q <= {shift_q[30:0], 1'b0};
					draw_q  <= {1'b0, draw_q[DRAW_W-1:1]};
				end
			end
			S_CHECK: begin
				res_q <= {33'd0, div_rem};
			end
			S_OUT: begin
				if (!out_valid_q || out_ready) begin
					value_q <= res_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign value     = value_q;

	// The serial units only run while a transaction is in flight.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !step_st.busy && !div_st.busy)
		else $error("arithmetic unit busy while idle");

	// The two serial units never run at the same time.
	assert property (@(posedge clk) disable iff (!arst_n)
		!(step_st.busy && div_st.busy))
		else $error("multiplier and remainder unit overlap");

	// An accepted transaction always leaves the block not ready in the following cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !in_ready)
		else $error("input accepted twice in a row");

	// A result is only loaded when the output register is free or draining.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT) && out_valid_q && !out_ready |=> out_valid_q && $stable(value_q))
		else $error("pending result overwritten");

endmodule

### hdl/lcg48_step.sv
// Bit-serial state update: one multiplier constant bit per cycle, MSB first.
module lcg48_step (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [lcg48_pkg::STATE_W-1:0]      cur_state,
	output logic [lcg48_pkg::STATE_W-1:0]      next_state,
	output lcg48_pkg::unit_status_t            status
);
	import lcg48_pkg::*;

	logic [STATE_W-1:0] acc_q;
	logic [STATE_W-1:0] x_q;
	logic [5:0]         cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [STATE_W-1:0] addend;

	assign addend = LCG_MUL[cnt_q] ? x_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'(MUL_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 6'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			x_q   <= cur_state;
		end else if (busy_q) begin
			acc_q <= {acc_q[STATE_W-2:0], 1'b0} + addend;
		end
	end

	assign next_state  = acc_q + LCG_ADD;
	assign status.busy = busy_q;
	assign status.done = done_q;

endmodule

### hdl/lcg48_div.sv
// Restoring remainder unit, one dividend bit per cycle.
module lcg48_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [lcg48_pkg::DRAW_W-1:0]      dividend,
	input  logic [lcg48_pkg::DRAW_W-1:0]      divisor,
	output logic [lcg48_pkg::DRAW_W-1:0]      remainder,
	output lcg48_pkg::unit_status_t           status
);
	import lcg48_pkg::*;

	logic [DRAW_W-1:0] n_q;
	logic [DRAW_W-1:0] d_q;
	logic [DRAW_W-1:0] rem_q;
	logic [4:0]        cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DRAW_W:0]   trial;
	logic [DRAW_W:0]   diff;

	assign trial = {rem_q, n_q[DRAW_W-1]};
	assign diff  = trial - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'(DRAW_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 5'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= dividend;
			d_q   <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			n_q <= {n_q[DRAW_W-2:0], 1'b0};
			// The partial remainder stays below the divisor, so it fits in DRAW_W bits.
			if (diff[DRAW_W]) begin
				rem_q <= trial[DRAW_W-1:0];
			end else begin
				rem_q <= diff[DRAW_W-1:0];
			end
		end
	end

	assign remainder   = rem_q;
	assign status.busy = busy_q;
	assign status.done = done_q;

endmodule
